FILE: rtl/utf8d_pkg.sv
// Shared types and constants for the UTF-8 validating decoder.
package utf8d_pkg;

  localparam int unsigned CpW  = 21;
  localparam int unsigned LenW = 3;

  localparam logic [CpW-1:0] RepCodeReset = 21'h00FFFD;
  localparam logic [CpW-1:0] MinCp2       = 21'h000080;
  localparam logic [CpW-1:0] MinCp3       = 21'h000800;
  localparam logic [CpW-1:0] MinCp4       = 21'h010000;
  localparam logic [CpW-1:0] SurrLo       = 21'h00D800;
  localparam logic [CpW-1:0] SurrHi       = 21'h00DFFF;
  localparam logic [CpW-1:0] MaxCp        = 21'h10FFFF;

  localparam logic [7:0] ContMask = 8'hC0;
  localparam logic [7:0] ContTag  = 8'h80;

  localparam logic [LenW-1:0] LenIdle = 3'd0;
  localparam logic [LenW-1:0] Len2    = 3'd2;
  localparam logic [LenW-1:0] Len3    = 3'd3;
  localparam logic [LenW-1:0] Len4    = 3'd4;

  // Pending multi-byte sequence
  typedef struct packed {
    logic [LenW-1:0] exp_len;
    logic [LenW-1:0] taken;
    logic [CpW-1:0]  acc;
  } seq_state_t;

  // One result item
  typedef struct packed {
    logic [CpW-1:0] cp;
    logic           rep;
    logic           fin;
  } result_t;

  // Results caused by one input byte: first result, then cnt-1 copies of tail
  typedef struct packed {
    logic [LenW-1:0] cnt;
    result_t         head;
    result_t         tail;
  } burst_t;

endpackage

FILE: rtl/utf8d_decode.sv
// Combinational next-state and result decode for one input byte.
module utf8d_decode (
  input  utf8d_pkg::seq_state_t cur_state,
  input  logic [7:0]            byte_in,
  input  logic [20:0]           rep_code,
  output utf8d_pkg::seq_state_t nxt_state,
  output utf8d_pkg::burst_t     burst
);
  import utf8d_pkg::*;

  seq_state_t      lead_state;
  result_t         lead_res;
  logic            lead_has;
  logic [CpW-1:0]  acc_ext;
  logic [LenW-1:0] taken_inc;
  logic            overlong;
  logic            bad_val;
  logic            is_cont;

  // Byte handled as if idle
  always_comb begin
    lead_state = '0;
    lead_res   = '0;
    lead_has   = 1'b0;
    unique case (byte_in) inside
      8'h00: begin
        lead_has     = 1'b1;
        lead_res.fin = 1'b1;
      end
      [8'h01:8'h7F]: begin
        lead_has    = 1'b1;
        lead_res.cp = {13'd0, byte_in};
      end
      [8'hC0:8'hDF]: begin
        lead_state.exp_len = Len2;
        lead_state.taken   = 3'd1;
        lead_state.acc     = {16'd0, byte_in[4:0]};
      end
      [8'hE0:8'hEF]: begin
        lead_state.exp_len = Len3;
        lead_state.taken   = 3'd1;
        lead_state.acc     = {17'd0, byte_in[3:0]};
      end
      [8'hF0:8'hF7]: begin
        lead_state.exp_len = Len4;
        lead_state.taken   = 3'd1;
        lead_state.acc     = {18'd0, byte_in[2:0]};
      end
      default: begin
        // stray continuation or F8-FF
        lead_has     = 1'b1;
        lead_res.cp  = rep_code;
        lead_res.rep = 1'b1;
      end
    endcase
  end

  // Continuation byte folded into the accumulator
  assign is_cont   = (byte_in & ContMask) == ContTag;
  assign acc_ext   = {cur_state.acc[CpW-7:0], byte_in[5:0]};
  assign taken_inc = cur_state.taken + 3'd1;
  assign overlong  = ((cur_state.exp_len == Len2) && (acc_ext < MinCp2)) ||
                     ((cur_state.exp_len == Len3) && (acc_ext < MinCp3)) ||
                     ((cur_state.exp_len == Len4) && (acc_ext < MinCp4));
  assign bad_val   = overlong || ((acc_ext >= SurrLo) && (acc_ext <= SurrHi)) ||
                     (acc_ext > MaxCp);

  always_comb begin
    nxt_state = '0;
    burst     = '0;
    if (cur_state.exp_len == LenIdle) begin
      nxt_state  = lead_state;
      burst.cnt  = {2'd0, lead_has};
      burst.head = lead_res;
    end else if (is_cont) begin
      if (taken_inc >= cur_state.exp_len) begin
        // sequence complete, block returns to idle
        if (bad_val) begin
          burst.cnt      = cur_state.exp_len;
          burst.head.cp  = rep_code;
          burst.head.rep = 1'b1;
          burst.tail     = burst.head;
        end else begin
          burst.cnt     = 3'd1;
          burst.head.cp = acc_ext;
        end
      end else begin
        nxt_state.exp_len = cur_state.exp_len;
        nxt_state.taken   = taken_inc;
        nxt_state.acc     = acc_ext;
      end
    end else begin
      // broken sequence: one replacement, then the byte taken afresh
      nxt_state      = lead_state;
      burst.cnt      = 3'd1 + {2'd0, lead_has};
      burst.head.cp  = rep_code;
      burst.head.rep = 1'b1;
      burst.tail     = lead_res;
    end
  end

endmodule

FILE: rtl/utf8_validating_decoder_core.sv
// UTF-8 validating decoder: top level with sequence state and result register.
// The first result of a byte is valid in the cycle after the byte is accepted.
// Throughput: one byte per cycle while out_ready is high; a byte that causes
//   more than one result keeps in_ready low until its last result is being taken.
// Reset (synchronous, rst_n low): idle, no pending sequence, no result pending,
//   replacement code 0xFFFD.
module utf8_validating_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_byte_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [20:0] out_code_point,
  output logic        out_is_replacement,
  output logic        out_is_end,
  output logic        out_last_of_run,
  input  logic        cfg_wr_en,
  input  logic [20:0] cfg_wr_data
);
  import utf8d_pkg::*;

  seq_state_t      state_r, state_nxt;
  burst_t          dec_burst;
  logic [LenW-1:0] cnt_r, cnt_nxt;
  logic            first_r, first_nxt;
  result_t         head_r, head_nxt;
  result_t         tail_r, tail_nxt;
  logic [CpW-1:0]  rep_code_r;
  logic            in_acc, out_acc;
  result_t         cur_res;

  utf8d_decode u_decode (
    .cur_state (state_r),
    .byte_in   (in_byte_in),
    .rep_code  (rep_code_r),
    .nxt_state (state_nxt),
    .burst     (dec_burst)
  );

  // Handshakes: take a new item once the last pending result leaves
  assign out_valid = cnt_r != 3'd0;
  assign out_acc   = out_valid && out_ready;
  assign in_ready  = (cnt_r == 3'd0) || ((cnt_r == 3'd1) && out_ready);
  assign in_acc    = in_valid && in_ready;

  // Result selection
  assign cur_res            = first_r ? head_r : tail_r;
  assign out_code_point     = cur_res.cp;
  assign out_is_replacement = cur_res.rep;
  assign out_is_end         = cur_res.fin;
  assign out_last_of_run    = cnt_r == 3'd1;

  // Burst register next values
  always_comb begin
    cnt_nxt   = cnt_r;
    first_nxt = first_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    if (in_acc) begin
      cnt_nxt   = dec_burst.cnt;
      first_nxt = 1'b1;
      head_nxt  = dec_burst.head;
      tail_nxt  = dec_burst.tail;
    end else if (out_acc) begin
      cnt_nxt   = cnt_r - 3'd1;
      first_nxt = 1'b0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= '0;
      cnt_r      <= '0;
      first_r    <= 1'b0;
      rep_code_r <= RepCodeReset;
    end else begin
      cnt_r   <= cnt_nxt;
      first_r <= first_nxt;
      if (in_acc) begin
        state_r <= state_nxt;
      end
      if (cfg_wr_en) begin
        rep_code_r <= cfg_wr_data;
      end
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

endmodule
